// ----- rtl/fsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants of the format specifier parser
// Parse phases, character codes, length and sign codes, and the
// conversion type lookup.
// ----------------------------------------------------------------------------
package fsp_pkg;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_FLAGS = 7'b0000010,
        PH_NUM   = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_LEN2  = 7'b0010000,
        PH_STAR  = 7'b0100000,
        PH_TYPE  = 7'b1000000
    } phase_t;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_H    = 3'd1;
    localparam logic [2:0] LEN_L    = 3'd2;
    localparam logic [2:0] LEN_J    = 3'd3;
    localparam logic [2:0] LEN_Z    = 3'd4;
    localparam logic [2:0] LEN_T    = 3'd5;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_SPACE = 2'd1;
    localparam logic [1:0] SIGN_PLUS  = 2'd2;

    localparam int FLAG_LEFT = 0;
    localparam int FLAG_ZPAD = 1;
    localparam int FLAG_ALT  = 2;

    localparam logic [7:0] SPEC_LEN_MAX = 8'hFF;
    localparam logic [3:0] STAR_MAX     = 4'hF;

    // Known conversion types: s S p d D i o O u U x X c C n %
    function automatic logic is_conv(input logic [7:0] c);
        logic hit;
        case (c)
            8'h73, 8'h53, 8'h70, 8'h64, 8'h44, 8'h69, 8'h6F, 8'h4F,
            8'h75, 8'h55, 8'h78, 8'h58, 8'h63, 8'h43, 8'h6E, 8'h25: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/format_spec_parser_top.sv -----
// ----------------------------------------------------------------------------
// format_spec_parser_top: printf conversion specifier parser
// Consumes a specifier one character per transaction and returns one
// transaction with the parsed fields at the conversion type character.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one transaction per character. s_cmd=1 opens a new
//   specifier (the percent sign, s_ch ignored); s_cmd=0 supplies the next
//   character in s_ch. Opening while a specifier is open drops the old one.
//   Characters outside an open specifier are dropped without a result.
//   Output channel (m_*): one transaction per specifier, at its terminating
//   character, carrying type, error flag, sign mode, flags, width,
//   precision, star count, length modifier and the consumed count.
//   A character waits in the input register until it is parsed; the parse
//   state and the result register are then written together, and the result
//   is valid on m_* from the result register.
//   Throughput: one character per cycle while no result waits on m_ready.
//   The parse state is updated once per character; the multiply-by-ten
//   accumulate of the width/precision digits is the longest path.
//   Reset (aresetn low, synchronous): no specifier open, all fields clear,
//   both channels empty.
//   Stall: while m_ready is low and a result waits, the parse stage holds
//   and the input register fills once; s_ready then drops until the
//   receiver takes the result.
// ----------------------------------------------------------------------------
module format_spec_parser_top
    import fsp_pkg::*;
#(
    parameter int NUMBER_BITS = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [7:0]             s_ch,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_type_char,
    output logic                   m_error,
    output logic [1:0]             m_sign_mode,
    output logic [2:0]             m_flags,
    output logic [NUMBER_BITS-1:0] m_field_width,
    output logic [NUMBER_BITS-1:0] m_field_precision,
    output logic                   m_has_precision,
    output logic [3:0]             m_star_count,
    output logic [2:0]             m_length_code,
    output logic                   m_length_doubled,
    output logic [7:0]             m_spec_length
);

    // Wide enough to hold ten times the largest number before saturation.
    localparam int MW = NUMBER_BITS + 4;
    localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [7:0] in_ch_reg;
    logic       advance;

    // Parse one buffered character whenever the result slot is free or
    // being drained this cycle.
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg <= s_cmd;
            in_ch_reg  <= s_ch;
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    phase_t                 phase_reg, phase_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic [NUMBER_BITS-1:0] width_reg, width_next;
    logic [NUMBER_BITS-1:0] prec_reg, prec_next;
    logic                   prec_seen_reg, prec_seen_next;
    logic [1:0]             sign_reg, sign_next;
    logic [2:0]             flag_reg, flag_next;
    logic [3:0]             stars_reg, stars_next;
    logic [2:0]             len_reg, len_next;
    logic                   dbl_reg, dbl_next;
    logic [7:0]             consumed_reg, consumed_next;
    logic                   last_digit_reg, last_digit_next;
    logic                   dot_wait_reg, dot_wait_next;
    logic                   emit;

    // Digit accumulate: optional multiply by ten, add, saturate.
    logic                   is_digit;
    logic [MW-1:0]          acc_ext;
    logic [MW-1:0]          acc_base;
    logic [MW-1:0]          acc_sum;
    logic [NUMBER_BITS-1:0] acc_sat;

    assign is_digit = (in_ch_reg >= CH_ZERO) && (in_ch_reg <= CH_NINE);
    assign acc_ext  = MW'(acc_reg);
    assign acc_base = last_digit_reg ? ((acc_ext << 3) + (acc_ext << 1)) : acc_ext;
    assign acc_sum  = acc_base + MW'(in_ch_reg[3:0]);
    assign acc_sat  = (acc_sum > MW'(NUM_MAX)) ? NUM_MAX : acc_sum[NUMBER_BITS-1:0];

    always_comb begin
        logic cont;
        logic [7:0] cnt_inc;
        logic [3:0] star_inc;
        logic [2:0] code;

        phase_next      = phase_reg;
        acc_next        = acc_reg;
        width_next      = width_reg;
        prec_next       = prec_reg;
        prec_seen_next  = prec_seen_reg;
        sign_next       = sign_reg;
        flag_next       = flag_reg;
        stars_next      = stars_reg;
        len_next        = len_reg;
        dbl_next        = dbl_reg;
        consumed_next   = consumed_reg;
        last_digit_next = last_digit_reg;
        dot_wait_next   = dot_wait_reg;
        emit            = 1'b0;

        cnt_inc  = (consumed_reg != SPEC_LEN_MAX) ? consumed_reg + 8'd1 : consumed_reg;
        star_inc = (stars_reg != STAR_MAX) ? stars_reg + 4'd1 : stars_reg;
        code     = LEN_NONE;
        cont     = 1'b0;

        if (in_cmd_reg) begin
            // Open a fresh specifier: clear every field and count the percent sign.
            phase_next      = PH_FLAGS;
            acc_next        = '0;
            width_next      = '0;
            prec_next       = '0;
            prec_seen_next  = 1'b0;
            sign_next       = SIGN_NONE;
            flag_next       = '0;
            stars_next      = '0;
            len_next        = LEN_NONE;
            dbl_next        = 1'b0;
            consumed_next   = 8'd1;
            last_digit_next = 1'b0;
            dot_wait_next   = 1'b0;
        end else if (phase_reg != PH_IDLE) begin
            cont = 1'b1;

            if (phase_next == PH_FLAGS) begin
                cont          = 1'b0;
                consumed_next = cnt_inc;
                if (in_ch_reg == CH_MINUS) begin
                    flag_next[FLAG_LEFT] = 1'b1;
                end else if (in_ch_reg == CH_ZERO) begin
                    flag_next[FLAG_ZPAD] = 1'b1;
                end else if (in_ch_reg == CH_HASH) begin
                    flag_next[FLAG_ALT] = 1'b1;
                end else if (in_ch_reg == CH_PLUS) begin
                    sign_next = SIGN_PLUS;
                end else if (in_ch_reg == CH_SPACE) begin
                    if (sign_reg != SIGN_PLUS) begin
                        sign_next = SIGN_SPACE;
                    end
                end else begin
                    cont          = 1'b1;
                    consumed_next = consumed_reg;
                    phase_next    = PH_NUM;
                end
            end

            if (cont && phase_next == PH_NUM) begin
                if (dot_wait_reg && !is_digit) begin
                    dot_wait_next = 1'b0;
                    if (prec_seen_reg) begin
                        prec_next = acc_reg;
                    end else begin
                        width_next = acc_reg;
                    end
                    phase_next = PH_LEN;
                end else if (is_digit) begin
                    acc_next        = acc_sat;
                    last_digit_next = 1'b1;
                    dot_wait_next   = 1'b0;
                    consumed_next   = cnt_inc;
                    cont            = 1'b0;
                end else if (in_ch_reg == CH_DOT) begin
                    // A second dot moves the digits so far into the width.
                    width_next      = acc_reg;
                    prec_next       = '0;
                    prec_seen_next  = 1'b1;
                    acc_next        = '0;
                    last_digit_next = 1'b0;
                    dot_wait_next   = 1'b1;
                    consumed_next   = cnt_inc;
                    cont            = 1'b0;
                end else if (in_ch_reg == CH_STAR) begin
                    // Count stars; they leave the number as is but end its run of digits.
                    stars_next      = star_inc;
                    last_digit_next = 1'b0;
                    consumed_next   = cnt_inc;
                    cont            = 1'b0;
                end else begin
                    if (prec_seen_reg) begin
                        prec_next = acc_reg;
                    end else begin
                        width_next = acc_reg;
                    end
                    phase_next = PH_LEN;
                end
            end

            if (cont && phase_next == PH_LEN) begin
                case (in_ch_reg)
                    CH_H:    code = LEN_H;
                    CH_L:    code = LEN_L;
                    CH_J:    code = LEN_J;
                    CH_Z:    code = LEN_Z;
                    CH_T:    code = LEN_T;
                    default: code = LEN_NONE;
                endcase
                if (code != LEN_NONE) begin
                    len_next      = code;
                    consumed_next = cnt_inc;
                    phase_next    = (code == LEN_H || code == LEN_L) ? PH_LEN2 : PH_STAR;
                    cont          = 1'b0;
                end else begin
                    phase_next = PH_STAR;
                end
            end

            if (cont && phase_next == PH_LEN2) begin
                phase_next = PH_STAR;
                if (in_ch_reg == CH_H || in_ch_reg == CH_L) begin
                    dbl_next      = 1'b1;
                    consumed_next = cnt_inc;
                    cont          = 1'b0;
                end
            end

            if (cont && phase_next == PH_STAR) begin
                phase_next = PH_TYPE;
                if (in_ch_reg == CH_STAR) begin
                    stars_next    = star_inc;
                    consumed_next = cnt_inc;
                    cont          = 1'b0;
                end
            end

            if (cont) begin
                // Terminating character: report and close the specifier.
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            acc_reg        <= '0;
            width_reg      <= '0;
            prec_reg       <= '0;
            prec_seen_reg  <= 1'b0;
            sign_reg       <= SIGN_NONE;
            flag_reg       <= '0;
            stars_reg      <= '0;
            len_reg        <= LEN_NONE;
            dbl_reg        <= 1'b0;
            consumed_reg   <= '0;
            last_digit_reg <= 1'b0;
            dot_wait_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            width_reg      <= width_next;
            prec_reg       <= prec_next;
            prec_seen_reg  <= prec_seen_next;
            sign_reg       <= sign_next;
            flag_reg       <= flag_next;
            stars_reg      <= stars_next;
            len_reg        <= len_next;
            dbl_reg        <= dbl_next;
            consumed_reg   <= consumed_next;
            last_digit_reg <= last_digit_next;
            dot_wait_reg   <= dot_wait_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_type_char       <= in_ch_reg;
            m_error           <= !is_conv(in_ch_reg);
            m_sign_mode       <= sign_next;
            m_flags           <= flag_next;
            m_field_width     <= width_next;
            m_field_precision <= prec_seen_next ? prec_next : '0;
            m_has_precision   <= prec_seen_next;
            m_star_count      <= stars_next;
            m_length_code     <= len_next;
            m_length_doubled  <= dbl_next;
            m_spec_length     <= consumed_next;
        end
    end

    assign m_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_emit_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> (phase_reg == PH_IDLE))
        else $error("specifier still open after its result");

    a_open_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (consumed_reg != 8'd0))
        else $error("open specifier with zero consumed count");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_valid_reg))
        else $error("result appeared without a parsed character");

    a_type_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_error) |-> is_conv(m_type_char))
        else $error("error flag clear for unknown type");

    a_prec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_precision) |-> (m_field_precision == '0))
        else $error("precision reported without a dot");

endmodule
